// ===== src/crq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crq_pkg - shared types, constants and helpers
// Register indexes, reset values, field widths and small pure functions used
// by the crop, resize and quantize datapath.
// ----------------------------------------------------------------------------
package crq_pkg;

  // field widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_DIM_W  = 11;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned ZP_W       = 8;
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned CH_W       = 8;

  // default largest frame dimension
  localparam int unsigned MAX_DIMENSION_DEF = 1024;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_QUANT_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Q_OFFSET   = 3'd5;

  // register reset values
  localparam logic [CFG_DIM_W-1:0]    RST_SRC_WIDTH  = 11'd320;
  localparam logic [CFG_DIM_W-1:0]    RST_SRC_HEIGHT = 11'd240;
  localparam logic [CFG_DIM_W-1:0]    RST_DST_WIDTH  = 11'd96;
  localparam logic [CFG_DIM_W-1:0]    RST_DST_HEIGHT = 11'd96;
  localparam logic [GAIN_W-1:0]       RST_QUANT_GAIN = 16'd256;
  localparam logic signed [ZP_W-1:0]  RST_Q_OFFSET   = -8'sd128;

  // int8 clamp limits and rounding constant
  localparam int Q_MIN = -128;
  localparam int Q_MAX = 127;
  localparam int unsigned Q_HALF = 128;

  // pixel picked by the scan stage
  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] pix;
  } sel_pix_t;

  // clamp a dimension to 1..max_dim
  function automatic int unsigned sat_dim(int unsigned v, int unsigned max_dim);
    if (v < 1) return 1;
    if (v > max_dim) return max_dim;
    return v;
  endfunction

  // column offset of the centred crop for the reset geometry
  function automatic int unsigned reset_col_offset(int unsigned max_dim);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    w = sat_dim(32'(RST_SRC_WIDTH), max_dim);
    h = sat_dim(32'(RST_SRC_HEIGHT), max_dim);
    c = (w < h) ? w : h;
    return (w - c) >> 1;
  endfunction

  // rgb565 channel widening by bit replication
  function automatic logic [CH_W-1:0] expand5(logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [CH_W-1:0] expand6(logic [5:0] v);
    return {v, v[5:4]};
  endfunction

endpackage

// ===== src/crq_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crq_div - iterative restoring divider
// Produces quotient and remainder one bit per cycle while busy after start.
// ----------------------------------------------------------------------------
module crq_div #(
  parameter int unsigned W = 11
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         busy,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  q_r;
  logic [W-1:0]  rem_r;

  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          ge;

  // one trial subtraction per cycle
  always_comb begin
    shifted = {rem_r, q_r[W-1]};
    diff    = shifted - {1'b0, den};
    ge      = (shifted >= {1'b0, den});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CW'(1);
      if (cnt_r == CW'(W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // quotient and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[W-1:0] : shifted[W-1:0];
      q_r   <= {q_r[W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quot = q_r;
  assign rem  = rem_r;

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider did not go busy after start");
`endif

endmodule

// ===== src/crq_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crq_scan - raster position tracking and pixel selection
// Follows the source raster, steps the crop/downscale targets with error
// accumulators and registers each selected pixel.
// ----------------------------------------------------------------------------
module crq_scan #(
  parameter int unsigned DIM_W        = 11,
  parameter int unsigned CNT_W        = 10,
  parameter int unsigned RESET_OFFSET = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic                      en,
  input  logic [crq_pkg::PIX_W-1:0] pixel_word,
  input  logic                      frame_start,
  input  logic [DIM_W-1:0]          src_w,
  input  logic [DIM_W-1:0]          src_h,
  input  logic [DIM_W-1:0]          dst_w,
  input  logic [DIM_W-1:0]          dst_h,
  input  logic [DIM_W-1:0]          col_off,
  input  logic [DIM_W-1:0]          col_q,
  input  logic [DIM_W-1:0]          col_rem,
  input  logic [DIM_W-1:0]          row_q,
  input  logic [DIM_W-1:0]          row_rem,
  output logic                      sel_valid,
  output crq_pkg::sel_pix_t         sel
);

  import crq_pkg::*;

  localparam int unsigned TGT_W = DIM_W + 1;

  logic [CNT_W-1:0] src_col_r, src_col_nxt;
  logic [CNT_W-1:0] src_row_r, src_row_nxt;
  logic [DIM_W-1:0] dst_col_r, dst_col_nxt;
  logic [DIM_W-1:0] dst_row_r, dst_row_nxt;
  logic [TGT_W-1:0] col_tgt_r, col_tgt_nxt;
  logic [TGT_W-1:0] row_tgt_r, row_tgt_nxt;
  logic [DIM_W-1:0] col_err_r, col_err_nxt;
  logic [DIM_W-1:0] row_err_r, row_err_nxt;
  logic             sel_valid_r;
  sel_pix_t         sel_r;

  // position after an optional frame restart
  logic [CNT_W-1:0] src_col_e, src_row_e;
  logic [DIM_W-1:0] dst_col_e, dst_row_e;
  logic [TGT_W-1:0] col_tgt_e, row_tgt_e;
  logic [DIM_W-1:0] col_err_e, row_err_e;

  logic             row_hit;
  logic             emit;
  logic             last;
  logic             col_end;
  logic             row_end;
  logic [TGT_W-1:0] col_err_sum, row_err_sum;
  logic             col_wrap, row_wrap;
  logic [DIM_W-1:0] col_err_step, row_err_step;
  logic [TGT_W-1:0] col_tgt_step, row_tgt_step;

  // frame start forces the pixel to position (0, 0)
  always_comb begin
    src_col_e = frame_start ? '0 : src_col_r;
    src_row_e = frame_start ? '0 : src_row_r;
    dst_col_e = frame_start ? '0 : dst_col_r;
    dst_row_e = frame_start ? '0 : dst_row_r;
    col_tgt_e = frame_start ? TGT_W'(col_off) : col_tgt_r;
    row_tgt_e = frame_start ? '0 : row_tgt_r;
    col_err_e = frame_start ? '0 : col_err_r;
    row_err_e = frame_start ? '0 : row_err_r;
  end

  // selection and end-of-line / end-of-frame decode
  always_comb begin
    row_hit = (dst_row_e < dst_h) && (TGT_W'(src_row_e) == row_tgt_e);
    emit    = row_hit && (dst_col_e < dst_w) && (TGT_W'(src_col_e) == col_tgt_e);
    last    = ((TGT_W'(dst_row_e) + TGT_W'(1)) == TGT_W'(dst_h)) &&
              ((TGT_W'(dst_col_e) + TGT_W'(1)) == TGT_W'(dst_w));
    col_end = (TGT_W'(src_col_e) + TGT_W'(1)) >= TGT_W'(src_w);
    row_end = (TGT_W'(src_row_e) + TGT_W'(1)) >= TGT_W'(src_h);
  end

  // error accumulator steps for the next target
  always_comb begin
    col_err_sum  = TGT_W'(col_err_e) + TGT_W'(col_rem);
    col_wrap     = col_err_sum >= TGT_W'(dst_w);
    col_err_step = col_wrap ? DIM_W'(col_err_sum - TGT_W'(dst_w)) : DIM_W'(col_err_sum);
    col_tgt_step = col_tgt_e + TGT_W'(col_q) + TGT_W'(col_wrap);
    row_err_sum  = TGT_W'(row_err_e) + TGT_W'(row_rem);
    row_wrap     = row_err_sum >= TGT_W'(dst_h);
    row_err_step = row_wrap ? DIM_W'(row_err_sum - TGT_W'(dst_h)) : DIM_W'(row_err_sum);
    row_tgt_step = row_tgt_e + TGT_W'(row_q) + TGT_W'(row_wrap);
  end

  // next position
  always_comb begin
    src_col_nxt = src_col_r;
    src_row_nxt = src_row_r;
    dst_col_nxt = dst_col_r;
    dst_row_nxt = dst_row_r;
    col_tgt_nxt = col_tgt_r;
    row_tgt_nxt = row_tgt_r;
    col_err_nxt = col_err_r;
    row_err_nxt = row_err_r;
    if (accept) begin
      src_row_nxt = src_row_e;
      dst_col_nxt = dst_col_e;
      dst_row_nxt = dst_row_e;
      col_tgt_nxt = col_tgt_e;
      row_tgt_nxt = row_tgt_e;
      col_err_nxt = col_err_e;
      row_err_nxt = row_err_e;
      if (emit) begin
        dst_col_nxt = dst_col_e + DIM_W'(1);
        col_tgt_nxt = col_tgt_step;
        col_err_nxt = col_err_step;
      end
      if (col_end) begin
        if (row_hit) begin
          dst_row_nxt = dst_row_e + DIM_W'(1);
          row_tgt_nxt = row_tgt_step;
          row_err_nxt = row_err_step;
        end
        dst_col_nxt = '0;
        col_tgt_nxt = TGT_W'(col_off);
        col_err_nxt = '0;
        src_col_nxt = '0;
        if (row_end) begin
          src_row_nxt = '0;
          dst_row_nxt = '0;
          row_tgt_nxt = '0;
          row_err_nxt = '0;
        end else begin
          src_row_nxt = src_row_e + CNT_W'(1);
        end
      end else begin
        src_col_nxt = src_col_e + CNT_W'(1);
      end
    end
  end

  // position state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r <= '0;
      src_row_r <= '0;
      dst_col_r <= '0;
      dst_row_r <= '0;
      col_tgt_r <= TGT_W'(RESET_OFFSET);
      row_tgt_r <= '0;
      col_err_r <= '0;
      row_err_r <= '0;
    end else begin
      src_col_r <= src_col_nxt;
      src_row_r <= src_row_nxt;
      dst_col_r <= dst_col_nxt;
      dst_row_r <= dst_row_nxt;
      col_tgt_r <= col_tgt_nxt;
      row_tgt_r <= row_tgt_nxt;
      col_err_r <= col_err_nxt;
      row_err_r <= row_err_nxt;
    end
  end

  // selected pixel register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_valid_r <= 1'b0;
    end else if (en) begin
      sel_valid_r <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en && accept) begin
      sel_r <= '{last: last, pix: pixel_word};
    end
  end

  assign sel_valid = sel_valid_r;
  assign sel       = sel_r;

`ifndef SYNTHESIS
  a_frame_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
    accept && frame_start && (src_w > DIM_W'(1)) |=>
      (src_col_r == CNT_W'(1)) && (src_row_r == '0))
    else $error("frame start did not restart the raster position");
`endif

endmodule

// ===== src/crq_pixel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crq_pixel - colour expansion, int8 quantisation and result register
// Widens the selected RGB565 pixel to RGB888, quantises each channel and
// holds the result until the consumer takes it.
// ----------------------------------------------------------------------------
module crq_pixel (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              sel_valid,
  input  crq_pkg::sel_pix_t                 sel,
  input  logic [crq_pkg::GAIN_W-1:0]        gain,
  input  logic signed [crq_pkg::ZP_W-1:0]   q_offset,
  output logic                              out_valid,
  output logic [crq_pkg::CH_W-1:0]          red,
  output logic [crq_pkg::CH_W-1:0]          green,
  output logic [crq_pkg::CH_W-1:0]          blue,
  output logic signed [crq_pkg::CH_W-1:0]   q_red,
  output logic signed [crq_pkg::CH_W-1:0]   q_green,
  output logic signed [crq_pkg::CH_W-1:0]   q_blue,
  output logic                              frame_last
);

  import crq_pkg::*;

  localparam int unsigned PROD_W = CH_W + GAIN_W;
  localparam int unsigned SUM_W  = GAIN_W + 2;

  // round(v * gain / 256) + zero point, clamped to int8
  function automatic logic signed [CH_W-1:0] quantize(
    logic [CH_W-1:0]        v,
    logic [GAIN_W-1:0]      g,
    logic signed [ZP_W-1:0] zp
  );
    logic [PROD_W-1:0]       prod;
    logic [PROD_W-1:0]       rnd;
    logic signed [SUM_W-1:0] sum;
    prod = PROD_W'(v) * PROD_W'(g);
    rnd  = prod + PROD_W'(Q_HALF);
    sum  = $signed({2'b00, rnd[PROD_W-1:CH_W]}) + SUM_W'(zp);
    if (sum < SUM_W'(Q_MIN)) return CH_W'(Q_MIN);
    if (sum > SUM_W'(Q_MAX)) return CH_W'(Q_MAX);
    return CH_W'(sum);
  endfunction

  logic                     out_valid_r;
  logic [CH_W-1:0]          red_r, green_r, blue_r;
  logic signed [CH_W-1:0]   q_red_r, q_green_r, q_blue_r;
  logic                     last_r;

  logic [CH_W-1:0]          red_c, green_c, blue_c;

  // rgb565 to rgb888
  always_comb begin
    red_c   = expand5(sel.pix[15:11]);
    green_c = expand6(sel.pix[10:5]);
    blue_c  = expand5(sel.pix[4:0]);
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sel_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (en) begin
      red_r     <= red_c;
      green_r   <= green_c;
      blue_r    <= blue_c;
      q_red_r   <= quantize(red_c, gain, q_offset);
      q_green_r <= quantize(green_c, gain, q_offset);
      q_blue_r  <= quantize(blue_c, gain, q_offset);
      last_r    <= sel.last;
    end
  end

  assign out_valid  = out_valid_r;
  assign red        = red_r;
  assign green      = green_r;
  assign blue       = blue_r;
  assign q_red      = q_red_r;
  assign q_green    = q_green_r;
  assign q_blue     = q_blue_r;
  assign frame_last = last_r;

endmodule

// ===== src/rgb565_crop_resize_quantize.sv =====
// Each input transaction's result is registered in the scan stage and then in the pixel stage.
// Throughput: one pixel per cycle while in_ready is high; unselected pixels give no result.
// A result held by out_ready low also holds in_ready low until it is taken.
// After reset and after each configuration write the two crop/scale step dividers
// are restarted, and in_ready stays low until both have finished.
// Reset is synchronous, active low, and restores the register defaults.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_crop_resize_quantize - streaming crop, downscale and int8 quantiser
// Crops a centred window, smaller side wide and all rows tall, from RGB565 video, picks
// nearest-neighbour pixels for the destination size, emits RGB888 and int8 quantised channels.
// ----------------------------------------------------------------------------
module rgb565_crop_resize_quantize #(
  parameter int unsigned MAX_DIMENSION = crq_pkg::MAX_DIMENSION_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [crq_pkg::PIX_W-1:0]           in_pixel_word,
  input  logic                                in_frame_start,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [crq_pkg::CH_W-1:0]            out_red,
  output logic [crq_pkg::CH_W-1:0]            out_green,
  output logic [crq_pkg::CH_W-1:0]            out_blue,
  output logic signed [crq_pkg::CH_W-1:0]     out_q_red,
  output logic signed [crq_pkg::CH_W-1:0]     out_q_green,
  output logic signed [crq_pkg::CH_W-1:0]     out_q_blue,
  output logic                                out_frame_last,
  input  logic                                cfg_we,
  input  logic [crq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [crq_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  import crq_pkg::*;

  localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned CNT_W = $clog2(MAX_DIMENSION);
  localparam int unsigned RESET_OFFSET = reset_col_offset(MAX_DIMENSION);

  logic [CFG_DIM_W-1:0]    src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [GAIN_W-1:0]       gain_r;
  logic signed [ZP_W-1:0]  zp_r;
  logic                    cal_start_r;

  logic [DIM_W-1:0] src_w, src_h, dst_w_sat, dst_h_sat;
  logic [DIM_W-1:0] col_side, dst_w, dst_h, col_off;
  logic [DIM_W-1:0] col_q, col_rem, row_q, row_rem;
  logic             col_busy, row_busy;
  logic             en;
  logic             accept;
  logic             sel_valid;
  sel_pix_t         sel;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= RST_SRC_WIDTH;
      src_h_r <= RST_SRC_HEIGHT;
      dst_w_r <= RST_DST_WIDTH;
      dst_h_r <= RST_DST_HEIGHT;
      gain_r  <= RST_QUANT_GAIN;
      zp_r    <= RST_Q_OFFSET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_w_r <= cfg_wdata[CFG_DIM_W-1:0];
        REG_SRC_HEIGHT: src_h_r <= cfg_wdata[CFG_DIM_W-1:0];
        REG_DST_WIDTH:  dst_w_r <= cfg_wdata[CFG_DIM_W-1:0];
        REG_DST_HEIGHT: dst_h_r <= cfg_wdata[CFG_DIM_W-1:0];
        REG_QUANT_GAIN: gain_r  <= cfg_wdata[GAIN_W-1:0];
        REG_Q_OFFSET:   zp_r    <= cfg_wdata[ZP_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry: saturated dimensions, crop side, centring offset
  always_comb begin
    src_w     = DIM_W'(sat_dim(32'(src_w_r), MAX_DIMENSION));
    src_h     = DIM_W'(sat_dim(32'(src_h_r), MAX_DIMENSION));
    dst_w_sat = DIM_W'(sat_dim(32'(dst_w_r), MAX_DIMENSION));
    dst_h_sat = DIM_W'(sat_dim(32'(dst_h_r), MAX_DIMENSION));
    col_side  = (src_w < src_h) ? src_w : src_h;
    dst_w     = (dst_w_sat > col_side) ? col_side : dst_w_sat;
    dst_h     = (dst_h_sat > src_h) ? src_h : dst_h_sat;
    col_off   = (src_w - col_side) >> 1;
  end

  // recompute step sizes after reset and after every register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_start_r <= 1'b1;
    end else begin
      cal_start_r <= cfg_we;
    end
  end

  crq_div #(
    .W (DIM_W)
  ) u_col_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cal_start_r),
    .num   (col_side),
    .den   (dst_w),
    .busy  (col_busy),
    .quot  (col_q),
    .rem   (col_rem)
  );

  crq_div #(
    .W (DIM_W)
  ) u_row_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cal_start_r),
    .num   (src_h),
    .den   (dst_h),
    .busy  (row_busy),
    .quot  (row_q),
    .rem   (row_rem)
  );

  // pipeline advance and input transaction
  assign en       = !out_valid || out_ready;
  assign in_ready = en && !cal_start_r && !col_busy && !row_busy;
  assign accept   = in_valid && in_ready;

  crq_scan #(
    .DIM_W        (DIM_W),
    .CNT_W        (CNT_W),
    .RESET_OFFSET (RESET_OFFSET)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .en          (en),
    .pixel_word  (in_pixel_word),
    .frame_start (in_frame_start),
    .src_w       (src_w),
    .src_h       (src_h),
    .dst_w       (dst_w),
    .dst_h       (dst_h),
    .col_off     (col_off),
    .col_q       (col_q),
    .col_rem     (col_rem),
    .row_q       (row_q),
    .row_rem     (row_rem),
    .sel_valid   (sel_valid),
    .sel         (sel)
  );

  crq_pixel u_pixel (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .sel_valid  (sel_valid),
    .sel        (sel),
    .gain       (gain_r),
    .q_offset   (zp_r),
    .out_valid  (out_valid),
    .red        (out_red),
    .green      (out_green),
    .blue       (out_blue),
    .q_red      (out_q_red),
    .q_green    (out_q_green),
    .q_blue     (out_q_blue),
    .frame_last (out_frame_last)
  );

`ifndef SYNTHESIS
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input taken while step sizes were being recomputed");

  a_reset_blocks_input: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready straight after reset");
`endif

endmodule

// ===== tb/sv/rgb565_crop_resize_quantize_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_crop_resize_quantize_tb - self-checking bench for the crop/resize core
// Streams RGB565 pixels through a set of crop and scale geometries, from
// degenerate 1x1 frames up to the largest size. Each accepted pixel is run
// through a cycle-free model of the crop, nearest-neighbour pick and int8
// quantiser. Every output transaction is then compared field by field against
// the oldest predicted pixel. Both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module rgb565_crop_resize_quantize_tb;
  import crq_pkg::*;

  localparam int unsigned LATENCY_WAIT = 4;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned PHASE_COUNT  = 14;
  localparam int unsigned PHASE_ITEMS  = 85;
  localparam int unsigned WHOLE_FRAME_MAX = 150;
  localparam int unsigned ERROR_PRINT_MAX = 40;

  typedef enum logic [1:0] {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_style_t;

  // one destination pixel as seen on the out_* ports
  typedef struct {
    logic [CH_W-1:0]        red;
    logic [CH_W-1:0]        green;
    logic [CH_W-1:0]        blue;
    logic signed [CH_W-1:0] q_red;
    logic signed [CH_W-1:0] q_green;
    logic signed [CH_W-1:0] q_blue;
    logic                   frame_last;
  } rgb_pixel_t;

  // predicts the picked pixels and holds those not yet seen on the output
  class crop_quant_scoreboard;
    logic [CFG_DIM_W-1:0]   src_w, src_h, dst_w, dst_h;
    logic [GAIN_W-1:0]      gain;
    logic signed [ZP_W-1:0] zero_pt;
    int unsigned src_col, src_row, dst_col, dst_row;
    int unsigned col_target, row_target, col_err, row_err;
    rgb_pixel_t  expected_pixels[$];
    int unsigned error_count;

    function new();
      src_w       = RST_SRC_WIDTH;
      src_h       = RST_SRC_HEIGHT;
      dst_w       = RST_DST_WIDTH;
      dst_h       = RST_DST_HEIGHT;
      gain        = RST_QUANT_GAIN;
      zero_pt     = RST_Q_OFFSET;
      error_count = 0;
      new_frame();
    endfunction

    static function int unsigned clamp_dim(int unsigned v);
      return (v == 0) ? 1 : (v > MAX_DIMENSION_DEF) ? MAX_DIMENSION_DEF : v;
    endfunction

    // width of the centred crop: the source height, or the width when it is narrower
    function int unsigned crop_w();
      int unsigned w;
      int unsigned h;
      w = clamp_dim(src_w);
      h = clamp_dim(src_h);
      return (w < h) ? w : h;
    endfunction

    function int unsigned crop_off();
      return (clamp_dim(src_w) - crop_w()) / 2;
    endfunction

    // no upscaling: destination size limited to the crop
    function int unsigned out_w();
      int unsigned d;
      d = clamp_dim(dst_w);
      return (d > crop_w()) ? crop_w() : d;
    endfunction

    function int unsigned out_h();
      int unsigned d;
      d = clamp_dim(dst_h);
      return (d > clamp_dim(src_h)) ? clamp_dim(src_h) : d;
    endfunction

    function void new_row();
      dst_col    = 0;
      col_target = crop_off();
      col_err    = 0;
    endfunction

    function void new_frame();
      src_col    = 0;
      src_row    = 0;
      dst_row    = 0;
      row_target = 0;
      row_err    = 0;
      new_row();
    endfunction

    // round half up, add zero point, saturate to int8
    function logic signed [CH_W-1:0] to_int8(logic [CH_W-1:0] v);
      int q;
      q = int'((32'(v) * 32'(gain) + Q_HALF) >> 8) + int'(zero_pt);
      if (q < Q_MIN) q = Q_MIN;
      if (q > Q_MAX) q = Q_MAX;
      return CH_W'(q);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SRC_WIDTH:  src_w   = data[CFG_DIM_W-1:0];
        REG_SRC_HEIGHT: src_h   = data[CFG_DIM_W-1:0];
        REG_DST_WIDTH:  dst_w   = data[CFG_DIM_W-1:0];
        REG_DST_HEIGHT: dst_h   = data[CFG_DIM_W-1:0];
        REG_QUANT_GAIN: gain    = data[GAIN_W-1:0];
        REG_Q_OFFSET:   zero_pt = data[ZP_W-1:0];
        default: ;
      endcase
    endfunction

    // advance the scan by one accepted pixel, queue a result if it is picked
    function void take_pixel(logic [PIX_W-1:0] pix, logic fs);
      int unsigned w, h, cw, dw, dh;
      logic [4:0]  r5, b5;
      logic [5:0]  g6;
      bit          row_hit;
      rgb_pixel_t  pick;
      w  = clamp_dim(src_w);
      h  = clamp_dim(src_h);
      cw = crop_w();
      dw = out_w();
      dh = out_h();
      if (fs) new_frame();

      row_hit = (dst_row < dh) && (src_row == row_target);
      if (row_hit && (dst_col < dw) && (src_col == col_target)) begin
        r5 = pix[15:11];
        g6 = pix[10:5];
        b5 = pix[4:0];
        pick.red        = {r5, r5[4:2]};
        pick.green      = {g6, g6[5:4]};
        pick.blue       = {b5, b5[4:2]};
        pick.q_red      = to_int8(pick.red);
        pick.q_green    = to_int8(pick.green);
        pick.q_blue     = to_int8(pick.blue);
        pick.frame_last = (dst_row + 1 == dh) && (dst_col + 1 == dw);
        expected_pixels.push_back(pick);
        // column step of floor(cw/dw) with remainder carried in the error term
        dst_col++;
        col_target += cw / dw;
        col_err    += cw % dw;
        if (col_err >= dw) begin
          col_err -= dw;
          col_target++;
        end
      end

      // end of source row, and of frame
      if (src_col + 1 >= w) begin
        if (row_hit) begin
          dst_row++;
          row_target += h / dh;
          row_err    += h % dh;
          if (row_err >= dh) begin
            row_err -= dh;
            row_target++;
          end
        end
        new_row();
        src_col = 0;
        if (src_row + 1 >= h) new_frame();
        else src_row++;
      end else begin
        src_col++;
      end
    endfunction

    task report(string msg);
      error_count++;
      if (error_count <= ERROR_PRINT_MAX) $display("[%0t] ERROR %s", $time, msg);
    endtask

    task check_pixel(rgb_pixel_t got);
      rgb_pixel_t want;
      if (expected_pixels.size() == 0) begin
        report("output transaction with no pixel pending");
        return;
      end
      want = expected_pixels.pop_front();
      if (got.red !== want.red)
        report($sformatf("red got %0d want %0d", got.red, want.red));
      if (got.green !== want.green)
        report($sformatf("green got %0d want %0d", got.green, want.green));
      if (got.blue !== want.blue)
        report($sformatf("blue got %0d want %0d", got.blue, want.blue));
      if (got.q_red !== want.q_red)
        report($sformatf("q_red got %0d want %0d", got.q_red, want.q_red));
      if (got.q_green !== want.q_green)
        report($sformatf("q_green got %0d want %0d", got.q_green, want.q_green));
      if (got.q_blue !== want.q_blue)
        report($sformatf("q_blue got %0d want %0d", got.q_blue, want.q_blue));
      if (got.frame_last !== want.frame_last)
        report($sformatf("frame_last got %0d want %0d", got.frame_last, want.frame_last));
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [PIX_W-1:0]       in_pixel_word;
  logic                   in_frame_start;
  logic                   out_valid;
  logic                   out_ready;
  logic [CH_W-1:0]        out_red;
  logic [CH_W-1:0]        out_green;
  logic [CH_W-1:0]        out_blue;
  logic signed [CH_W-1:0] out_q_red;
  logic signed [CH_W-1:0] out_q_green;
  logic signed [CH_W-1:0] out_q_blue;
  logic                   out_frame_last;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  crop_quant_scoreboard sb;

  int unsigned  stalled_cycles;
  int unsigned  burst_left;
  bit           gaps_on;
  bit           hold_request;
  int unsigned  hold_left;
  int unsigned  ready_tick;
  ready_style_t ready_style;
  logic [7:0]   ready_mask;

  rgb565_crop_resize_quantize u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_word  (in_pixel_word),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_q_red      (out_q_red),
    .out_q_green    (out_q_green),
    .out_q_blue     (out_q_blue),
    .out_frame_last (out_frame_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // monitor: score transactions and register writes seen at each edge
  always @(posedge clk) begin
    rgb_pixel_t got;
    bit         moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.red        = out_red;
        got.green      = out_green;
        got.blue       = out_blue;
        got.q_red      = out_q_red;
        got.q_green    = out_q_green;
        got.q_blue     = out_q_blue;
        got.frame_last = out_frame_last;
        sb.check_pixel(got);
        moved = 1'b1;
      end
      if (in_valid && in_ready) begin
        sb.take_pixel(in_pixel_word, in_frame_start);
        moved = 1'b1;
      end
      if (cfg_we) begin
        sb.set_reg(cfg_index, cfg_wdata);
        moved = 1'b1;
      end
      if (moved) stalled_cycles = 0;
      else stalled_cycles++;
    end
  end

  // receiver: long hold on request, otherwise the per-phase stall style
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    ready_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (ready_style)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
        default:      out_ready <= ready_mask[ready_tick[2:0]];
      endcase
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    do @(posedge clk); while (stalled_cycles < STALL_LIMIT);
    $display("[%0t] timeout: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 11))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'hF800;
      3:       return 16'h07E0;
      4:       return 16'h001F;
      default: return PIX_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // offer one pixel, with a random gap at the end of a burst
  task automatic send_pixel(logic [PIX_W-1:0] pix, logic fs);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_valid       <= 1'b1;
    in_pixel_word  <= pix;
    in_frame_start <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (sb.expected_pixels.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // reprogram every register once the block has gone quiet
  task automatic configure(logic [CFG_DATA_W-1:0] sw, logic [CFG_DATA_W-1:0] sh,
                           logic [CFG_DATA_W-1:0] dw, logic [CFG_DATA_W-1:0] dh,
                           logic [CFG_DATA_W-1:0] qg, logic [ZP_W-1:0] zp);
    wait_drained();
    repeat (LATENCY_WAIT) @(posedge clk);
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    write_reg(REG_QUANT_GAIN, qg);
    // upper data bits are ignored by the zero point register
    write_reg(REG_Q_OFFSET, {8'($urandom_range(0, 255)), zp});
    cfg_we <= 1'b0;
  endtask

  // 5x3 source, 3x2 destination: one flagged frame, a self-wrapping start, a restart
  task automatic run_directed();
    logic [PIX_W-1:0] corner_pixels [15];
    int unsigned k;
    corner_pixels = '{16'h5555, 16'h0000, 16'hFFFF, 16'hF800, 16'h8410,
                      16'h1082, 16'h07E0, 16'h001F, 16'hAAAA, 16'h7BEF,
                      16'h0821, 16'hF7DE, 16'hE71C, 16'h18E3, 16'hFFFF};
    for (k = 0; k < 15; k++) send_pixel(corner_pixels[k], k == 0);
    for (k = 0; k < 4; k++) send_pixel(corner_pixels[k + 6], 1'b0);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hF81F, 1'b0);
    stop_sending();
  endtask

  // whole or cut-short frames with random content where frames are small, else a stream
  task automatic run_phase(int unsigned n_items, bit with_hold);
    int unsigned npix;
    int unsigned sent;
    int unsigned frame_len;
    int unsigned k;
    bit          flag;
    bit          paused;
    logic        fs;
    npix   = crop_quant_scoreboard::clamp_dim(sb.src_w) *
             crop_quant_scoreboard::clamp_dim(sb.src_h);
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      if (npix <= WHOLE_FRAME_MAX) begin
        frame_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, npix) : npix;
        flag      = ($urandom_range(0, 7) != 0);
      end else begin
        frame_len = n_items;
        flag      = 1'($urandom_range(0, 1));
      end
      for (k = 0; k < frame_len && sent < n_items; k++) begin
        fs = (k == 0 && flag) || ($urandom_range(0, 59) == 0);
        send_pixel(pick_pixel(), fs);
        sent++;
        if (with_hold && sent == 10) hold_request = 1'b1;
        // sender pause until the output side has caught up
        if (!paused && sent >= n_items / 2) begin
          paused = 1'b1;
          stop_sending();
          wait_drained();
        end
      end
    end
    stop_sending();
  endtask

  // stimulus
  initial begin
    int unsigned ph;
    int unsigned sh;
    int unsigned sw;
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_pixel_word  = '0;
    in_frame_start = 1'b0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_SRC_WIDTH;
    cfg_wdata      = '0;
    stalled_cycles = 0;
    burst_left     = 0;
    gaps_on        = 1'b0;
    hold_request   = 1'b0;
    hold_left      = 0;
    ready_tick     = 0;
    ready_style    = READY_ALWAYS;
    ready_mask     = 8'hFF;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(5, 3, 3, 2, 256, 8'h80);
    run_directed();

    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        // all dimensions zero: every pixel is a whole 1x1 frame
        0: configure(0, 0, 0, 0, 0, 8'h80);
        // beyond the largest size, saturating quantiser
        1: configure(16'hFFFF, 2047, 2047, 1024, 16'hFFFF, 8'h7F);
        // one pixel per largest frame
        2: configure(1024, 1024, 1, 1, 16'hFFFF, 8'h80);
        // width below height and upscale requested
        3: configure(3, 7, 2, 9, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        4: configure(8, 8, 8, 8, 256, 8'h00);
        5: configure(6, 4, 10, 5, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        default: begin
          if ($urandom_range(0, 5) == 0) begin
            sh = $urandom_range(20, 64);
            sw = $urandom_range(sh, 100);
          end else begin
            sh = $urandom_range(1, 10);
            sw = ($urandom_range(0, 4) == 0) ? $urandom_range(1, sh)
                                             : $urandom_range(sh, 14);
          end
          configure(16'(sw), 16'(sh), 16'($urandom_range(1, sh + 2)),
                    16'($urandom_range(1, sh + 2)),
                    16'(($urandom_range(0, 1) == 0) ? $urandom_range(200, 320)
                                                    : $urandom_range(0, 65535)),
                    8'($urandom_range(0, 255)));
        end
      endcase
      if (ph == 0) begin
        ready_style = READY_ALWAYS;
        gaps_on     = 1'b0;
      end else begin
        ready_style = ready_style_t'($urandom_range(0, 2));
        ready_mask  = 8'($urandom_range(1, 255));
        gaps_on     = ($urandom_range(0, 2) != 0);
      end
      run_phase(PHASE_ITEMS, ph == 4);
    end

    wait_drained();
    repeat (LATENCY_WAIT) @(posedge clk);
    if (sb.error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
